FILE: rtl/dpc_pkg.sv
// Package for the depth pixel back-projection block: field types, sizes and register codes.
package dpc_pkg;

    // Pixel coordinates use only the low COORD_BITS bits of the 12-bit fields
    localparam int COORD_BITS = 12;
    localparam int PIX_W      = 12;
    localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((1 << COORD_BITS) - 1);

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    // Divider: 32-bit magnitude by 16-bit focal length, two quotient bits per stage
    localparam int NUM_W      = 32;
    localparam int DEN_W      = 16;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;

    // Input register, multiply, divider stages, round/saturate
    localparam int PIPE_LAT   = DIV_STAGES + 3;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL_X  = 2'd0,
        CFG_FOCAL_Y  = 2'd1,
        CFG_CENTER_X = 2'd2,
        CFG_CENTER_Y = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [15:0] depth_mm;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } t_pixel;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [15:0]        point_z;
        logic [7:0]         red_out;
        logic [7:0]         green_out;
        logic [7:0]         blue_out;
        logic               point_valid;
    } t_point;

    // Per-item data that rides alongside the divider
    typedef struct packed {
        logic [15:0] depth;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        neg_x;
        logic        neg_y;
        logic        nz_x;
        logic        nz_y;
    } t_side;

endpackage

FILE: rtl/dpc_div.sv
// Pipelined restoring divider: unsigned 32-bit numerator by 16-bit divisor, quotient and remainder.
module dpc_div (
    input  logic                      i_clk,
    input  logic [dpc_pkg::NUM_W-1:0] i_num,
    input  logic [dpc_pkg::DEN_W-1:0] i_den,
    output logic [dpc_pkg::NUM_W-1:0] o_quo,
    output logic [dpc_pkg::DEN_W-1:0] o_rem
);
    import dpc_pkg::*;

    // Shift word: unconsumed numerator bits at the top, quotient bits fill from the bottom
    logic [NUM_W-1:0] r_nq  [DIV_STAGES];
    logic [DEN_W-1:0] r_rem [DIV_STAGES];
    logic [NUM_W-1:0] n_nq  [DIV_STAGES];
    logic [DEN_W-1:0] n_rem [DIV_STAGES];

    always_comb begin
        logic [NUM_W-1:0] nq;
        logic [DEN_W-1:0] rem;
        logic [DEN_W:0]   trial;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                nq  = i_num;
                rem = '0;
            end else begin
                nq  = r_nq[s-1];
                rem = r_rem[s-1];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                trial = {rem, nq[NUM_W-1]};
                if (trial >= {1'b0, i_den}) begin
                    rem = DEN_W'(trial - {1'b0, i_den});
                    nq  = {nq[NUM_W-2:0], 1'b1};
                end else begin
                    rem = trial[DEN_W-1:0];
                    nq  = {nq[NUM_W-2:0], 1'b0};
                end
            end
            n_nq[s]  = nq;
            n_rem[s] = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_nq[s]  <= n_nq[s];
            r_rem[s] <= n_rem[s];
        end
    end

    assign o_quo = r_nq[DIV_STAGES-1];
    assign o_rem = r_rem[DIV_STAGES-1];

endmodule

FILE: rtl/depth_pixel_to_colored_point.sv
// Each pixel taken on start gives one point, strobed by o_valid.
// Throughput: one pixel per clock; busy stays low, the pipeline never stalls.
// Depth is set by the 16-stage divider (two quotient bits per stage) plus
// input, multiply and round/saturate stages. Results cannot be held off.
// Reset clears valid bits and loads focal 600.0/600.0 and centre 320.0/240.0 (Q12.4).
module depth_pixel_to_colored_point (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  dpc_pkg::t_pixel               i_pixel,
    output logic                          o_valid,
    output dpc_pkg::t_point               o_point,
    input  logic                          i_cfg_we,
    input  logic [dpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dpc_pkg::CFG_W-1:0]     i_cfg_data
);
    import dpc_pkg::*;

    logic [CFG_W-1:0] r_focal_x;
    logic [CFG_W-1:0] r_focal_y;
    logic [CFG_W-1:0] r_center_x;
    logic [CFG_W-1:0] r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= 16'd9600;
            r_focal_y  <= 16'd9600;
            r_center_x <= 16'd5120;
            r_center_y <= 16'd3840;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Stage 1: offset from principal point, split into sign and magnitude
    logic [PIX_W-1:0] col_m;
    logic [PIX_W-1:0] row_m;
    logic [16:0]      diff_x;
    logic [16:0]      diff_y;
    logic [15:0]      mag_x;
    logic [15:0]      mag_y;

    assign col_m  = i_pixel.column & COORD_MASK;
    assign row_m  = i_pixel.row & COORD_MASK;
    assign diff_x = {1'b0, col_m, 4'b0000} - {1'b0, r_center_x};
    assign diff_y = {1'b0, row_m, 4'b0000} - {1'b0, r_center_y};
    assign mag_x  = diff_x[16] ? 16'(-diff_x) : diff_x[15:0];
    assign mag_y  = diff_y[16] ? 16'(-diff_y) : diff_y[15:0];

    logic        r_v1;
    t_side       r_side1;
    logic [15:0] r_mag_x;
    logic [15:0] r_mag_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept;
        end
        r_side1.depth <= i_pixel.depth_mm;
        r_side1.red   <= i_pixel.red_in;
        r_side1.green <= i_pixel.green_in;
        r_side1.blue  <= i_pixel.blue_in;
        r_side1.neg_x <= diff_x[16];
        r_side1.neg_y <= diff_y[16];
        r_side1.nz_x  <= (mag_x != '0);
        r_side1.nz_y  <= (mag_y != '0);
        r_mag_x       <= mag_x;
        r_mag_y       <= mag_y;
    end

    // Stage 2: numerator magnitude = |offset| * depth
    logic             r_v2;
    t_side            r_side2;
    logic [NUM_W-1:0] r_prod_x;
    logic [NUM_W-1:0] r_prod_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_side2  <= r_side1;
        r_prod_x <= NUM_W'(r_mag_x) * NUM_W'(r_side1.depth);
        r_prod_y <= NUM_W'(r_mag_y) * NUM_W'(r_side1.depth);
    end

    logic [NUM_W-1:0] quo_x;
    logic [NUM_W-1:0] quo_y;
    logic [DEN_W-1:0] rem_x;
    logic [DEN_W-1:0] rem_y;

    dpc_div u_div_x (
        .i_clk (i_clk),
        .i_num (r_prod_x),
        .i_den (r_focal_x),
        .o_quo (quo_x),
        .o_rem (rem_x)
    );

    dpc_div u_div_y (
        .i_clk (i_clk),
        .i_num (r_prod_y),
        .i_den (r_focal_y),
        .o_quo (quo_y),
        .o_rem (rem_y)
    );

    // Side data delay line, matched to the divider
    logic  r_vd    [DIV_STAGES];
    t_side r_sided [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_vd[s] <= 1'b0;
            end
        end else begin
            r_vd[0] <= r_v2;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_vd[s] <= r_vd[s-1];
            end
        end
        r_sided[0] <= r_side2;
        for (int s = 1; s < DIV_STAGES; s++) begin
            r_sided[s] <= r_sided[s-1];
        end
    end

    // Round half away from zero, apply sign, saturate; zero focal saturates by sign, a zero offset gives 0
    function automatic logic signed [31:0] finish_axis(
        input logic [NUM_W-1:0] quo,
        input logic [DEN_W-1:0] rem,
        input logic [DEN_W-1:0] den,
        input logic             neg,
        input logic             nz
    );
        logic [NUM_W:0]     qr;
        logic signed [31:0] res;
        qr = {1'b0, quo} + (NUM_W+1)'({rem, 1'b0} >= {1'b0, den});
        if (den == '0) begin
            if (!nz)      res = '0;
            else if (neg) res = S32_MIN;
            else          res = S32_MAX;
        end else if (neg) begin
            if (qr > 33'h0_8000_0000) res = S32_MIN;
            else                      res = 32'(-qr);
        end else begin
            if (qr > 33'h0_7FFF_FFFF) res = S32_MAX;
            else                      res = qr[31:0];
        end
        return res;
    endfunction

    t_side  side_q;
    logic   pt_ok;
    t_point n_point;

    assign side_q = r_sided[DIV_STAGES-1];
    assign pt_ok  = (side_q.depth != '0);

    always_comb begin
        n_point = '0;
        if (pt_ok) begin
            n_point.point_x     = finish_axis(quo_x, rem_x, r_focal_x, side_q.neg_x, side_q.nz_x);
            n_point.point_y     = finish_axis(quo_y, rem_y, r_focal_y, side_q.neg_y, side_q.nz_y);
            n_point.point_z     = side_q.depth;
            n_point.red_out     = side_q.red;
            n_point.green_out   = side_q.green;
            n_point.blue_out    = side_q.blue;
            n_point.point_valid = 1'b1;
        end
    end

    logic   r_out_vld;
    t_point r_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vd[DIV_STAGES-1];
        end
        r_point <= n_point;
    end

    assign o_valid = r_out_vld;
    assign o_point = r_point;

    // A result beat only follows a pixel taken the full latency earlier
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, PIPE_LAT))
        else $error("result beat without matching pixel");

    // An empty point carries nothing
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_point.point_valid) |->
            (o_point.point_x == '0) && (o_point.point_y == '0) && (o_point.point_z == '0) &&
            (o_point.red_out == '0) && (o_point.green_out == '0) && (o_point.blue_out == '0))
        else $error("empty point has nonzero fields");

    // A valid point always has depth
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_point.point_valid) |-> (o_point.point_z != '0))
        else $error("valid point with zero depth");

    // Side data and divider stay in step: an output beat has a live item at the divider tail
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_vd[DIV_STAGES-1]) && $past(r_v2, DIV_STAGES + 1))
        else $error("pipeline valid bits out of step");

endmodule

FILE: tb/tb_depth_pixel_to_colored_point.sv
// Self-checking testbench for the depth pixel to coloured point back-projection block.
module tb_depth_pixel_to_colored_point;
    import dpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_pixel               i_pixel    = '0;
    logic                 o_valid;
    t_point               o_point;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Local copy of the camera registers
    logic [15:0] cam_fx = 16'd9600;
    logic [15:0] cam_fy = 16'd9600;
    logic [15:0] cam_cx = 16'd5120;
    logic [15:0] cam_cy = 16'd3840;

    t_point points_due[$];
    int     errors       = 0;
    int     pixels_sent  = 0;
    int     points_seen  = 0;
    int     camera_sets  = 0;
    int     cycle_count  = 0;
    bit     steady       = 1'b0;

    depth_pixel_to_colored_point uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (i_pixel),
        .o_valid    (o_valid),
        .o_point    (o_point),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points outstanding",
                     cycle_count, points_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // round((pix*16 - centre) * depth / focal), half away from zero, clamped to s32
    function automatic logic signed [31:0] backproject(logic [11:0] pix, logic [15:0] centre,
                                                       logic [15:0] depth, logic [15:0] focal);
        longint offset;
        longint prod;
        longint mag;
        longint quot;
        offset = longint'(pix & COORD_MASK) * 64'sd16 - longint'(centre);
        prod   = offset * longint'(depth);
        mag    = (prod < 0) ? -prod : prod;
        if (focal == 16'd0) begin
            if (mag == 0) return 32'sd0;
            return (prod < 0) ? S32_MIN : S32_MAX;
        end
        quot = (2 * mag + longint'(focal)) / (2 * longint'(focal));
        if (prod < 0)
            return (quot > 64'sd2147483648) ? S32_MIN : 32'(-quot);
        return (quot > 64'sd2147483647) ? S32_MAX : 32'(quot);
    endfunction

    function automatic t_point predict_point(t_pixel px);
        t_point p;
        p = '0;
        if (px.depth_mm != 16'd0) begin
            p.point_x     = backproject(px.column, cam_cx, px.depth_mm, cam_fx);
            p.point_y     = backproject(px.row, cam_cy, px.depth_mm, cam_fy);
            p.point_z     = px.depth_mm;
            p.red_out     = px.red_in;
            p.green_out   = px.green_in;
            p.blue_out    = px.blue_in;
            p.point_valid = 1'b1;
        end
        return p;
    endfunction

    function automatic t_pixel make_pixel(int col, int row, int depth, int r, int g, int b);
        t_pixel px;
        px.column   = 12'(col);
        px.row      = 12'(row);
        px.depth_mm = 16'(depth);
        px.red_in   = 8'(r);
        px.green_in = 8'(g);
        px.blue_in  = 8'(b);
        return px;
    endfunction

    function automatic t_pixel rand_pixel();
        int sel;
        int depth;
        sel = $urandom_range(0, 99);
        if (sel < 8)       depth = 0;
        else if (sel < 14) depth = 65535;
        else if (sel < 30) depth = $urandom_range(1, 255);
        else               depth = $urandom_range(1, 65535);
        return make_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), depth,
                          $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    function automatic int pick_gap();
        int sel;
        if (steady) return 0;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // start stays high between back-to-back beats; lowered only for a gap
    task automatic send_pixel(t_pixel px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
        points_due.push_back(predict_point(px));
        pixels_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (points_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write enable held high across the four register beats
    task automatic set_camera(int fx, int fy, int cx, int cy);
        logic [15:0] vals[4];
        t_cfg_idx    idx;
        wait_drained();
        vals = '{16'(fx), 16'(fy), 16'(cx), 16'(cy)};
        for (int i = 0; i < 4; i++) begin
            idx = t_cfg_idx'(i);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            case (idx)
                CFG_FOCAL_X:  cam_fx = vals[i];
                CFG_FOCAL_Y:  cam_fy = vals[i];
                CFG_CENTER_X: cam_cx = vals[i];
                CFG_CENTER_Y: cam_cy = vals[i];
            endcase
        end
        i_cfg_we <= 1'b0;
        camera_sets++;
    endtask

    task automatic check_field(string what, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : point_check
        t_point want;
        if (i_rst_n && o_valid) begin
            points_seen++;
            if (points_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected point, expected none got x=%0d y=%0d z=%0d",
                         $time, $signed(o_point.point_x), $signed(o_point.point_y),
                         o_point.point_z);
            end else begin
                want = points_due.pop_front();
                check_field("point_x", $signed(want.point_x), $signed(o_point.point_x));
                check_field("point_y", $signed(want.point_y), $signed(o_point.point_y));
                check_field("point_z", want.point_z, o_point.point_z);
                check_field("red_out", want.red_out, o_point.red_out);
                check_field("green_out", want.green_out, o_point.green_out);
                check_field("blue_out", want.blue_out, o_point.blue_out);
                check_field("point_valid", want.point_valid, o_point.point_valid);
            end
        end
    end

    // reset camera; field extremes, empty points, pixel on the principal point
    task automatic test_extremes();
        send_pixel(make_pixel(0, 0, 0, 255, 255, 255));
        send_pixel(make_pixel(4095, 4095, 65535, 0, 0, 0));
        send_pixel(make_pixel(0, 4095, 65535, 255, 0, 255));
        send_pixel(make_pixel(4095, 0, 1, 0, 255, 0));
        send_pixel(make_pixel(320, 240, 65535, 170, 85, 170));
        send_pixel(make_pixel(4095, 4095, 0, 85, 170, 85));
        send_pixel(make_pixel(0, 0, 1, 1, 2, 3));
        send_pixel(make_pixel(2730, 1365, 43690, 128, 64, 32));
    endtask

    // focal 2.0, then 3.0: quotients landing exactly on a half
    task automatic test_rounding_ties();
        set_camera(32, 32, 16, 0);
        send_pixel(make_pixel(0, 1, 1, 10, 20, 30));
        send_pixel(make_pixel(1, 0, 3, 40, 50, 60));
        set_camera(48, 48, 24, 8);
        send_pixel(make_pixel(0, 1, 1, 70, 80, 90));
        send_pixel(make_pixel(3, 0, 5, 100, 110, 120));
    endtask

    // zero focal: sign-only saturation, zero numerator stays zero
    task automatic test_zero_focal();
        set_camera(0, 0, 5120, 3840);
        send_pixel(make_pixel(400, 100, 1000, 1, 1, 1));
        send_pixel(make_pixel(320, 240, 1000, 2, 2, 2));
        send_pixel(make_pixel(100, 400, 1, 3, 3, 3));
        send_pixel(make_pixel(100, 400, 0, 4, 4, 4));
    endtask

    task automatic test_saturation();
        set_camera(1, 1, 0, 65535);
        send_pixel(make_pixel(4095, 0, 65535, 9, 9, 9));
        send_pixel(make_pixel(0, 4095, 65535, 8, 8, 8));
        set_camera(65535, 65535, 65535, 0);
        send_pixel(make_pixel(0, 4095, 65535, 7, 7, 7));
        send_pixel(make_pixel(4095, 0, 1, 6, 6, 6));
    endtask

    task automatic run_random(int count, bit hold_midway);
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
            if (hold_midway && n == count / 2) wait_drained();
            send_pixel(rand_pixel());
        end
        steady = 1'b0;
    endtask

    // random pixels under a sequence of camera settings, extremes included
    task automatic test_camera_sweep();
        set_camera(9600, 9600, 5120, 3840);
        run_random(350, 1'b1);
        set_camera(1, 1, 0, 0);
        run_random(150, 1'b0);
        set_camera(65535, 65535, 65535, 65535);
        run_random(300, 1'b0);
        set_camera($urandom_range(4000, 20000), $urandom_range(4000, 20000),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
        run_random(350, 1'b0);
        set_camera(16, 16, 32768, 32768);
        run_random(300, 1'b0);
        set_camera($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
        run_random(350, 1'b0);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_rounding_ties();
        test_zero_focal();
        test_saturation();
        test_camera_sweep();

        wait_drained();
        repeat (PIPE_LAT + 4) @(posedge i_clk);

        $display("sent %0d pixels, checked %0d points across %0d camera settings",
                 pixels_sent, points_seen, camera_sets);
        $display("incl. zero depth, zero focal, rounding ties and s32 saturation");
        if (errors == 0 && points_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d points missing", errors, points_due.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/dpc_pkg.sv
rtl/dpc_div.sv
rtl/depth_pixel_to_colored_point.sv
tb/tb_depth_pixel_to_colored_point.sv
